// ----- hw/rtl/set_assoc_lru_cache_model_macros.svh -----
// Assertion macros for the set-associative LRU cache model checker.
// No dependencies; included by the checker file.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SALC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SALC_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/salc_pkg.sv -----
// Shared types, constants and codes for the set-associative LRU cache model.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package salc_pkg;

  localparam int MAX_SET_BITS   = 6;
  localparam int MAX_WAYS       = 8;
  localparam int ADDR_WIDTH     = 48;
  localparam int MAX_BLOCK_BITS = 32;

  localparam int TAG_W    = ADDR_WIDTH;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W    = $clog2(MAX_WAYS + 1);
  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_AW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

  localparam int SET_BITS_W   = 3;
  localparam int WAYS_W       = 4;
  localparam int BLOCK_BITS_W = 6;
  localparam int SHIFT_W      = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;
  localparam int TOTAL_W      = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET_BITS = 2'd2;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_STORE  = 2'd1,
    MODE_MODIFY = 2'd2,
    MODE_IFETCH = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    mode_t                 mode;
    logic [ADDR_WIDTH-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         hits_added;
    logic               missed;
    logic               evicted;
    logic [TOTAL_W-1:0] total_hits;
    logic [TOTAL_W-1:0] total_misses;
    logic [TOTAL_W-1:0] total_evictions;
  } out_item_t;

  typedef struct packed {
    logic [MAX_WAYS-1:0][TAG_W-1:0] tags;
    logic [MAX_WAYS-1:0]            valid;
    logic [MAX_WAYS-1:0][WAY_W-1:0] ranks;
  } set_row_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic [CNT_W-1:0] count;
    logic             empty_found;
    logic [WAY_W-1:0] empty_way;
    logic             lru_found;
    logic [WAY_W-1:0] lru_way;
    logic [WAY_W-1:0] lru_rank;
  } scan_res_t;

  typedef struct packed {
    logic [1:0] hits;
    logic       missed;
    logic       evicted;
  } upd_flags_t;

endpackage

// ----- hw/rtl/salc_set_ram.sv -----
// Set row memory: one row per set holding tags, valid bits and LRU ranks.
// Depends on salc_pkg; one write port, one registered read port.
`timescale 1ns / 1ps

module salc_set_ram
  import salc_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [SET_AW-1:0] waddr,
  input  set_row_t          wdata,
  input  logic              re,
  input  logic [SET_AW-1:0] raddr,
  output set_row_t          rdata
);

  set_row_t mem_r [NUM_SETS];
  set_row_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/salc_way_scan.sv -----
// Shared tag compare unit: visits one way per step and accumulates hit,
// fill count, first empty way and LRU candidate. Depends on salc_pkg.
`timescale 1ns / 1ps

module salc_way_scan
  import salc_pkg::*;
(
  input  logic             clk,
  input  logic             clr,
  input  logic             step,
  input  logic [WAY_W-1:0] way,
  input  logic [TAG_W-1:0] tag,
  input  logic [TAG_W-1:0] line_tag,
  input  logic             line_valid,
  input  logic [WAY_W-1:0] line_rank,
  output scan_res_t        res
);

  scan_res_t res_r;
  scan_res_t res_nxt;

  always_comb begin
    res_nxt = res_r;
    if (clr) begin
      res_nxt = '0;
    end else if (step) begin
      if (line_valid) begin
        res_nxt.count = res_r.count + CNT_W'(1);
        if (line_tag == tag && !res_r.hit) begin
          res_nxt.hit     = 1'b1;
          res_nxt.hit_way = way;
        end
        if (!res_r.lru_found || line_rank >= res_r.lru_rank) begin
          res_nxt.lru_found = 1'b1;
          res_nxt.lru_way   = way;
          res_nxt.lru_rank  = line_rank;
        end
      end else if (!res_r.empty_found) begin
        res_nxt.empty_found = 1'b1;
        res_nxt.empty_way   = way;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

// ----- hw/rtl/salc_row_update.sv -----
// Row update: picks hit, fill or victim way and ages the LRU ranks of a set.
// Depends on salc_pkg; fed by the way scan result.
`timescale 1ns / 1ps

module salc_row_update
  import salc_pkg::*;
(
  input  set_row_t         row,
  input  scan_res_t        res,
  input  logic [TAG_W-1:0] tag,
  input  mode_t            mode,
  input  logic [CNT_W-1:0] ways_eff,
  output set_row_t         row_new,
  output upd_flags_t       flags
);

  logic [WAY_W-1:0] victim;
  logic [WAY_W-1:0] hit_rank;
  logic             is_modify;

  always_comb begin
    row_new   = row;
    flags     = '0;
    victim    = res.lru_way;
    hit_rank  = row.ranks[res.hit_way];
    is_modify = (mode == MODE_MODIFY);
    if (res.hit) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (row.valid[w] && row.ranks[w] < hit_rank) begin
          row_new.ranks[w] = row.ranks[w] + WAY_W'(1);
        end
      end
      row_new.ranks[res.hit_way] = '0;
      flags.hits = is_modify ? 2'd2 : 2'd1;
    end else begin
      flags.missed = 1'b1;
      if (res.count < ways_eff && res.empty_found) begin
        victim = res.empty_way;
      end else begin
        flags.evicted         = 1'b1;
        row_new.valid[victim] = 1'b0;
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (row_new.valid[w]) begin
          row_new.ranks[w] = row.ranks[w] + WAY_W'(1);
        end
      end
      row_new.tags[victim]  = tag;
      row_new.valid[victim] = 1'b1;
      row_new.ranks[victim] = '0;
      flags.hits = is_modify ? 2'd1 : 2'd0;
    end
  end

endmodule

// ----- hw/rtl/set_assoc_lru_cache_model.sv -----
// Channel | ports                               | item accepted when
// in      | in_valid, in_ready, in_item         | in_valid && in_ready
// out     | out_valid, out_ready, out_item      | out_valid && out_ready
// cfg     | cfg_valid, cfg_ready, cfg_index/data| cfg_valid && cfg_ready
// Load, store and modify items pass from accept to the next accept through read,
// load, 8 way-scan steps through the one tag comparator and write back. Instruction
// fetch items skip the read and the scan. Reset: rst_n synchronous; a row
// valid flag per set makes every line read invalid at once, no clearing pass.
// A stalled result holds the block in its write-back state.
// Top level; depends on salc_pkg, salc_set_ram, salc_way_scan, salc_row_update.
`timescale 1ns / 1ps

module set_assoc_lru_cache_model
  import salc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [SET_BITS_W-1:0]   set_bits_r;
  logic [WAYS_W-1:0]       ways_r;
  logic [BLOCK_BITS_W-1:0] block_bits_r;

  mode_t                 mode_r;
  logic [ADDR_WIDTH-1:0] addr_r;
  logic [TAG_W-1:0]      tag_r;
  logic [SET_AW-1:0]     set_r;
  logic [WAY_W-1:0]      way_cnt_r;
  set_row_t              row_r;
  logic [NUM_SETS-1:0]   row_valid_r;

  logic [TOTAL_W-1:0] hit_total_r, miss_total_r, evict_total_r;
  out_item_t          out_item_r;
  logic               out_valid_r;

  logic [SET_BITS_W-1:0]   s_eff;
  logic [BLOCK_BITS_W-1:0] b_eff;
  logic [CNT_W-1:0]        ways_eff;
  logic [SHIFT_W-1:0]      tag_shift;
  logic [ADDR_WIDTH-1:0]   set_shifted;
  logic [SET_AW-1:0]       set_mask;
  logic [TAG_W-1:0]        tag_calc;
  logic [SET_AW-1:0]       set_calc;

  logic mem_re, mem_we, scan_clr, scan_step, done_fire, is_ifetch;

  set_row_t   rdata;
  set_row_t   row_new;
  scan_res_t  scan_res;
  upd_flags_t flags;

  // effective configuration
  always_comb begin
    s_eff = (set_bits_r > SET_BITS_W'(MAX_SET_BITS)) ? SET_BITS_W'(MAX_SET_BITS) : set_bits_r;
    b_eff = (block_bits_r > BLOCK_BITS_W'(MAX_BLOCK_BITS)) ?
            BLOCK_BITS_W'(MAX_BLOCK_BITS) : block_bits_r;
    if (ways_r == '0) begin
      ways_eff = CNT_W'(1);
    end else if (ways_r > WAYS_W'(MAX_WAYS)) begin
      ways_eff = CNT_W'(MAX_WAYS);
    end else begin
      ways_eff = CNT_W'(ways_r);
    end
  end

  // address split
  always_comb begin
    tag_shift   = SHIFT_W'(s_eff) + SHIFT_W'(b_eff);
    tag_calc    = TAG_W'(addr_r >> tag_shift);
    set_shifted = addr_r >> b_eff;
    set_mask    = ~({SET_AW{1'b1}} << s_eff);
    set_calc    = set_shifted[SET_AW-1:0] & set_mask;
  end

  assign is_ifetch = (mode_r == MODE_IFETCH);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_item.mode == MODE_IFETCH) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (way_cnt_r == WAY_W'(MAX_WAYS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_re    = 1'b0;
    scan_clr  = 1'b0;
    scan_step = 1'b0;
    done_fire = 1'b0;
    case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_READ: mem_re    = 1'b1;
      ST_LOAD: scan_clr  = 1'b1;
      ST_SCAN: scan_step = 1'b1;
      ST_DONE: done_fire = !out_valid_r || out_ready;
      default: in_ready  = 1'b0;
    endcase
  end

  assign mem_we    = done_fire && !is_ifetch;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      set_bits_r    <= '0;
      ways_r        <= WAYS_W'(1);
      block_bits_r  <= BLOCK_BITS_W'(4);
      way_cnt_r     <= '0;
      row_valid_r   <= '0;
      hit_total_r   <= '0;
      miss_total_r  <= '0;
      evict_total_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SET_INDEX_BITS:    set_bits_r   <= cfg_data[SET_BITS_W-1:0];
          CFG_WAYS_IN_USE:       ways_r       <= cfg_data[WAYS_W-1:0];
          CFG_BLOCK_OFFSET_BITS: block_bits_r <= cfg_data;
          default:               set_bits_r   <= set_bits_r;
        endcase
      end
      if (scan_clr) begin
        way_cnt_r <= '0;
      end else if (scan_step) begin
        way_cnt_r <= way_cnt_r + WAY_W'(1);
      end
      if (done_fire) begin
        out_valid_r <= 1'b1;
        if (!is_ifetch) begin
          row_valid_r[set_r] <= 1'b1;
          hit_total_r        <= hit_total_r + TOTAL_W'(flags.hits);
          miss_total_r       <= miss_total_r + TOTAL_W'(flags.missed);
          evict_total_r      <= evict_total_r + TOTAL_W'(flags.evicted);
        end
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_item.mode;
      addr_r <= in_item.address;
    end
    if (mem_re) begin
      tag_r <= tag_calc;
      set_r <= set_calc;
    end
    if (scan_clr) begin
      row_r.tags  <= rdata.tags;
      row_r.valid <= row_valid_r[set_r] ? rdata.valid : '0;
      row_r.ranks <= row_valid_r[set_r] ? rdata.ranks : '0;
    end
    if (done_fire) begin
      if (is_ifetch) begin
        out_item_r.hits_added      <= '0;
        out_item_r.missed          <= 1'b0;
        out_item_r.evicted         <= 1'b0;
        out_item_r.total_hits      <= hit_total_r;
        out_item_r.total_misses    <= miss_total_r;
        out_item_r.total_evictions <= evict_total_r;
      end else begin
        out_item_r.hits_added      <= flags.hits;
        out_item_r.missed          <= flags.missed;
        out_item_r.evicted         <= flags.evicted;
        out_item_r.total_hits      <= hit_total_r + TOTAL_W'(flags.hits);
        out_item_r.total_misses    <= miss_total_r + TOTAL_W'(flags.missed);
        out_item_r.total_evictions <= evict_total_r + TOTAL_W'(flags.evicted);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  salc_set_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (set_r),
    .wdata (row_new),
    .re    (mem_re),
    .raddr (set_calc),
    .rdata (rdata)
  );

  salc_way_scan u_scan (
    .clk        (clk),
    .clr        (scan_clr),
    .step       (scan_step),
    .way        (way_cnt_r),
    .tag        (tag_r),
    .line_tag   (row_r.tags[way_cnt_r]),
    .line_valid (row_r.valid[way_cnt_r]),
    .line_rank  (row_r.ranks[way_cnt_r]),
    .res        (scan_res)
  );

  salc_row_update u_upd (
    .row      (row_r),
    .res      (scan_res),
    .tag      (tag_r),
    .mode     (mode_r),
    .ways_eff (ways_eff),
    .row_new  (row_new),
    .flags    (flags)
  );

endmodule

// ----- hw/rtl/salc_checker.sv -----
// Port-level checker for the set-associative LRU cache model, bound to the top.
// Depends on salc_pkg and set_assoc_lru_cache_model_macros.svh.
`timescale 1ns / 1ps
`include "set_assoc_lru_cache_model_macros.svh"

module salc_checker
  import salc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  `SALC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready after accept")
  `SALC_ASSERT_IMP(a_evict_needs_miss, clk, rst_n, out_valid && out_item.evicted, out_item.missed, "evict without miss")
  `SALC_ASSERT_IMP(a_double_hit_no_miss, clk, rst_n, out_valid && out_item.hits_added == 2'd2, !out_item.missed, "double hit with miss")
  `SALC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item), "stalled item changed")

endmodule

bind set_assoc_lru_cache_model salc_checker u_salc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// ----- tb/sv/cache_result_checker.sv -----
// Result checker for the set-associative LRU cache: predicts each access outcome
// and the running totals, then compares every result item. Depends on salc_pkg.
`timescale 1ns / 1ps

module cache_result_checker
  import salc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_item,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    results_checked,
  output int                    evictions_seen
);

  logic [TAG_W-1:0]        tag_mem   [NUM_SETS][MAX_WAYS];
  logic                    valid_mem [NUM_SETS][MAX_WAYS];
  logic [WAY_W-1:0]        rank_mem  [NUM_SETS][MAX_WAYS];
  logic [SET_BITS_W-1:0]   set_bits_reg;
  logic [WAYS_W-1:0]       ways_reg;
  logic [BLOCK_BITS_W-1:0] block_bits_reg;
  logic [TOTAL_W-1:0]      hit_total;
  logic [TOTAL_W-1:0]      miss_total;
  logic [TOTAL_W-1:0]      evict_total;
  out_item_t               expected_results [$];

  function automatic out_item_t cache_access(in_item_t acc);
    int unsigned           s, b, e, set_idx, count;
    int unsigned           hit_way, empty_way, lru_way, victim;
    logic [WAY_W-1:0]      hit_rank, lru_rank;
    logic [TAG_W-1:0]      tag;
    logic [ADDR_WIDTH-1:0] set_mask;
    out_item_t             res;
    res = '0;
    if (acc.mode != MODE_IFETCH) begin
      s = (set_bits_reg > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_reg;
      b = (block_bits_reg > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : block_bits_reg;
      e = (ways_reg == 0) ? 1 : (ways_reg > MAX_WAYS) ? MAX_WAYS : ways_reg;
      tag = acc.address >> (s + b);
      set_mask = (ADDR_WIDTH'(1) << s) - 1;
      set_idx = int'((acc.address >> b) & set_mask);
      count = 0;
      hit_way = MAX_WAYS;
      empty_way = MAX_WAYS;
      lru_way = MAX_WAYS;
      lru_rank = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (valid_mem[set_idx][w]) begin
          count++;
          if (tag_mem[set_idx][w] == tag && hit_way == MAX_WAYS) hit_way = w;
          if (lru_way == MAX_WAYS || rank_mem[set_idx][w] >= lru_rank) begin
            lru_way = w;
            lru_rank = rank_mem[set_idx][w];
          end
        end else if (empty_way == MAX_WAYS) begin
          empty_way = w;
        end
      end
      if (hit_way != MAX_WAYS) begin
        hit_rank = rank_mem[set_idx][hit_way];
        for (int w = 0; w < MAX_WAYS; w++)
          if (valid_mem[set_idx][w] && rank_mem[set_idx][w] < hit_rank)
            rank_mem[set_idx][w] = rank_mem[set_idx][w] + 1'b1;
        rank_mem[set_idx][hit_way] = '0;
        res.hits_added = (acc.mode == MODE_MODIFY) ? 2'd2 : 2'd1;
      end else begin
        res.missed = 1'b1;
        if (count < e && empty_way != MAX_WAYS) begin
          victim = empty_way;
        end else begin
          victim = lru_way;
          res.evicted = 1'b1;
          valid_mem[set_idx][victim] = 1'b0;
        end
        for (int w = 0; w < MAX_WAYS; w++)
          if (valid_mem[set_idx][w]) rank_mem[set_idx][w] = rank_mem[set_idx][w] + 1'b1;
        tag_mem[set_idx][victim] = tag;
        valid_mem[set_idx][victim] = 1'b1;
        rank_mem[set_idx][victim] = '0;
        res.hits_added = (acc.mode == MODE_MODIFY) ? 2'd1 : 2'd0;
      end
      hit_total = hit_total + res.hits_added;
      miss_total = miss_total + res.missed;
      evict_total = evict_total + res.evicted;
    end
    res.total_hits = hit_total;
    res.total_misses = miss_total;
    res.total_evictions = evict_total;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SETS; i++)
        for (int w = 0; w < MAX_WAYS; w++) begin
          valid_mem[i][w] = 1'b0;
          rank_mem[i][w] = '0;
        end
      set_bits_reg = '0;
      ways_reg = 4'd1;
      block_bits_reg = 6'd4;
      hit_total = '0;
      miss_total = '0;
      evict_total = '0;
      expected_results.delete();
      fail_count = 0;
      results_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SET_INDEX_BITS:    set_bits_reg = cfg_data[SET_BITS_W-1:0];
          CFG_WAYS_IN_USE:       ways_reg = cfg_data[WAYS_W-1:0];
          CFG_BLOCK_OFFSET_BITS: block_bits_reg = cfg_data[BLOCK_BITS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_results.push_back(cache_access(in_item));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result item at %0t: %p", $realtime, out_item);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (out_item.hits_added !== want.hits_added ||
              out_item.missed !== want.missed ||
              out_item.evicted !== want.evicted ||
              out_item.total_hits !== want.total_hits ||
              out_item.total_misses !== want.total_misses ||
              out_item.total_evictions !== want.total_evictions) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch on result %0d: expected hits_added=%0d missed=%0d ",
                        "evicted=%0d totals=%0d/%0d/%0d, got hits_added=%0d missed=%0d ",
                        "evicted=%0d totals=%0d/%0d/%0d"},
                       results_checked, want.hits_added, want.missed, want.evicted,
                       want.total_hits, want.total_misses, want.total_evictions,
                       out_item.hits_added, out_item.missed, out_item.evicted,
                       out_item.total_hits, out_item.total_misses,
                       out_item.total_evictions);
          end
        end
      end
    end
    pending = expected_results.size();
    evictions_seen = int'(evict_total);
  end

endmodule

// ----- tb/sv/tb_set_assoc_lru_cache_model.sv -----
// Testbench top for set_assoc_lru_cache_model: drives accesses and register writes,
// idles both channels at random. Depends on salc_pkg and cache_result_checker.
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_model;
  import salc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 150;
  localparam int IDLE_PCT       = 22;
  localparam int HOLDOFF_CYCLES = 400;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int                    fail_count;
  int                    pending;
  int                    results_checked;
  int                    evictions_seen;
  int                    settings_used = 1;
  int unsigned           eff_sets = 0;
  int unsigned           eff_ways = 1;
  int unsigned           eff_block = 4;
  logic                  calm = 1'b0;
  logic                  holdoff_req = 1'b0;
  logic                  holdoff_armed = 1'b0;
  int unsigned           holdoff_left = 0;
  logic [ADDR_WIDTH-1:0] last_addr = '0;

  always #10 clk = ~clk;

  set_assoc_lru_cache_model u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cache_result_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .evictions_seen  (evictions_seen)
  );

  always @(negedge clk) begin
    if (holdoff_req && !holdoff_armed) begin
      holdoff_armed <= 1'b1;
      holdoff_left  <= HOLDOFF_CYCLES;
      out_ready     <= 1'b0;
    end else if (holdoff_left != 0) begin
      out_ready <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic send_access(input mode_t mode, input logic [ADDR_WIDTH-1:0] addr);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{mode: mode, address: addr};
    last_addr = addr;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic program_cache(input logic [CFG_DATA_W-1:0] sb, wb, bb);
    write_reg(CFG_SET_INDEX_BITS, sb);
    write_reg(CFG_WAYS_IN_USE, wb);
    write_reg(CFG_BLOCK_OFFSET_BITS, bb);
    cfg_valid <= 1'b0;
    eff_sets = (sb[SET_BITS_W-1:0] > MAX_SET_BITS) ? MAX_SET_BITS : sb[SET_BITS_W-1:0];
    eff_ways = (wb[WAYS_W-1:0] == 0) ? 1 :
               (wb[WAYS_W-1:0] > MAX_WAYS) ? MAX_WAYS : wb[WAYS_W-1:0];
    eff_block = (bb > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : bb;
    settings_used++;
  endtask

  // Mostly a small pool of tags over a few sets so hits and evictions are common.
  function automatic logic [ADDR_WIDTH-1:0] make_address();
    logic [ADDR_WIDTH-1:0] tag, set_idx, offs;
    int unsigned           pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return ADDR_WIDTH'({$urandom, $urandom});
    if (pick < 30) return last_addr;
    tag = ADDR_WIDTH'($urandom_range(0, 2 * eff_ways + 1));
    set_idx = ADDR_WIDTH'($urandom_range(0, 3)) & ((ADDR_WIDTH'(1) << eff_sets) - 1);
    offs = ADDR_WIDTH'({$urandom, $urandom}) & ((ADDR_WIDTH'(1) << eff_block) - 1);
    return (tag << (eff_sets + eff_block)) | (set_idx << eff_block) | offs;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_reg(input int unsigned lo, hi);
    if ($urandom_range(0, 9) == 0) return CFG_DATA_W'($urandom_range(0, 63));
    return CFG_DATA_W'($urandom_range(lo, hi));
  endfunction

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // default settings: one set, direct mapped, 16-byte blocks
    send_access(MODE_LOAD, 48'h0);
    send_access(MODE_LOAD, 48'hF);
    send_access(MODE_MODIFY, 48'h0);
    send_access(MODE_STORE, 48'h10);
    send_access(MODE_MODIFY, 48'h20);
    send_access(MODE_IFETCH, 48'h20);
    send_access(MODE_LOAD, 48'hFFFF_FFFF_FFFF);
    finish_phase();

    // saturate set and block bits, write ways with zero low bits; the spare index must change nothing
    write_reg(CFG_SPARE_INDEX, 6'h3F);
    program_cache(6'h3F, 6'h30, 6'h3F);
    send_access(MODE_LOAD, 48'hFFFF_FFFF_FFFF);
    send_access(MODE_STORE, 48'hFFFF_FFFF_FFFF);
    send_access(MODE_LOAD, 48'h0);
    finish_phase();

    // fill all eight ways of set zero, then modify one of the resident lines
    program_cache(6'd6, 6'd15, 6'd0);
    for (int k = 1; k <= MAX_WAYS; k++) send_access(MODE_LOAD, ADDR_WIDTH'(k) << 6);
    send_access(MODE_MODIFY, ADDR_WIDTH'(2) << 6);
    finish_phase();

    // shrink associativity with the set still full
    program_cache(6'd6, 6'd2, 6'd0);
    send_access(MODE_LOAD, ADDR_WIDTH'(1) << 6);
    send_access(MODE_LOAD, ADDR_WIDTH'(20) << 6);
    send_access(MODE_IFETCH, 48'hAAAA_5555_AAAA);

    for (int p = 0; p < PHASES; p++) begin
      finish_phase();
      if (p == 0)
        program_cache(6'd0, 6'd1, 6'd0);
      else if (p == PHASES - 1)
        program_cache(6'd6, 6'd8, 6'd32);
      else
        program_cache(pick_reg(0, 6), pick_reg(1, 8), pick_reg(0, 32));
      calm <= (p == 4);
      if (p == 2) holdoff_req <= 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_access(mode_t'($urandom_range(0, 3)), make_address());
    end

    finish_phase();
    repeat (24) @(negedge clk);
    $display("Checked %0d result items over %0d cache settings, %0d evictions predicted,",
             results_checked, settings_used, evictions_seen);
    $display("including a %0d-cycle output hold-off and saturated register values.",
             HOLDOFF_CYCLES);
    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- set_assoc_lru_cache_model.f -----
+incdir+hw/rtl
hw/rtl/salc_pkg.sv
hw/rtl/salc_set_ram.sv
hw/rtl/salc_way_scan.sv
hw/rtl/salc_row_update.sv
hw/rtl/set_assoc_lru_cache_model.sv
hw/rtl/salc_checker.sv
tb/sv/cache_result_checker.sv
tb/sv/tb_set_assoc_lru_cache_model.sv
